// ===== rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and codes of the two-level LRU cache tag block.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 8;

    localparam logic [STATUS_W-1:0] ST_NONE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RH   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WH   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WM   = 3'd4;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK
    } back_state_t;

    typedef struct packed {
        logic rd_en;
        logic upd_en;
        logic fill;
        logic clr_en;
    } lvl_ctrl_t;

endpackage

// ===== rtl/tlc_ram.sv =====
// ----------------------------------------------------------------------------
// tlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/tlc_level.sv =====
// ----------------------------------------------------------------------------
// tlc_level
// One cache level: set row RAM (valid, ages, tags), way compare, LRU update.
// ----------------------------------------------------------------------------
module tlc_level #(
    parameter int SETS = 64,
    parameter int WAYS = 4,
    parameter int TW   = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tlc_pkg::lvl_ctrl_t                  ctrl,
    input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] rd_set,
    input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] clr_set,
    input  logic [TW-1:0]                       tag,
    output logic                                hit
);

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RW = WAYS * (1 + AW + TW);
    localparam int AB = WAYS;
    localparam int TB = WAYS + WAYS * AW;

    logic [SW-1:0] set_reg;
    logic [RW-1:0] rd_row;
    logic [RW-1:0] wr_row;
    logic [SW-1:0] wr_set;
    logic          we;

    logic [AW-1:0] age [WAYS];
    logic [WAYS-1:0] hit_vec;
    logic [AW-1:0] hit_way;
    logic [AW-1:0] vic_way;
    logic [AW-1:0] sel;
    logic [AW-1:0] mine;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg <= '0;
        end
        else if (ctrl.rd_en)
        begin
            set_reg <= rd_set;
        end
    end

    always_comb
    begin
        hit_way = '0;
        vic_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            age[w]     = rd_row[AB + w*AW +: AW];
            hit_vec[w] = rd_row[w] && (rd_row[TB + w*TW +: TW] == tag);
            if (hit_vec[w])
            begin
                hit_way = AW'(w);
            end
            if (age[w] == AW'(WAYS - 1))
            begin
                vic_way = AW'(w);
            end
        end
        hit  = |hit_vec;
        sel  = hit ? hit_way : vic_way;
        mine = age[sel];
    end

    always_comb
    begin
        wr_row = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (ctrl.clr_en)
            begin
                wr_row[w]                = 1'b0;
                wr_row[AB + w*AW +: AW]  = AW'(WAYS - 1 - w);
                wr_row[TB + w*TW +: TW]  = '0;
            end
            else if (AW'(w) == sel)
            begin
                wr_row[AB + w*AW +: AW] = '0;
                if (!hit)
                begin
                    wr_row[w]               = 1'b1;
                    wr_row[TB + w*TW +: TW] = tag;
                end
            end
            else if (age[w] < mine)
            begin
                wr_row[AB + w*AW +: AW] = age[w] + AW'(1);
            end
        end
        we     = ctrl.clr_en || (ctrl.upd_en && (hit || ctrl.fill));
        wr_set = ctrl.clr_en ? clr_set : set_reg;
    end

    tlc_ram #(
        .WIDTH(RW),
        .DEPTH(SETS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(wr_set),
        .wdata(wr_row),
        .re   (ctrl.rd_en),
        .raddr(rd_set),
        .rdata(rd_row)
    );

endmodule

// ===== rtl/tlc_front.sv =====
// ----------------------------------------------------------------------------
// tlc_front
// Accepts requests, splits the address per level, queues two decoded items.
// ----------------------------------------------------------------------------
module tlc_front #(
    parameter int OFF1 = 6,
    parameter int SB1  = 6,
    parameter int SW1  = 6,
    parameter int TW1  = 20,
    parameter int OFF2 = 6,
    parameter int SB2  = 8,
    parameter int SW2  = 8,
    parameter int TW2  = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_write,
    input  logic [tlc_pkg::ADDR_W-1:0]  in_addr,
    output logic                        q_valid,
    input  logic                        q_pop,
    output logic                        q_write,
    output logic [SW1-1:0]              q_set1,
    output logic [TW1-1:0]              q_tag1,
    output logic [SW2-1:0]              q_set2,
    output logic [TW2-1:0]              q_tag2
);

    localparam int EW = 1 + SW1 + TW1 + SW2 + TW2;

    logic [tlc_pkg::ADDR_W-1:0] blk1;
    logic [tlc_pkg::ADDR_W-1:0] blk2;
    logic [EW-1:0] entry;
    logic [EW-1:0] head;
    logic [EW-1:0] buf_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;

    always_comb
    begin
        blk1  = in_addr >> OFF1;
        blk2  = in_addr >> OFF2;
        entry = {TW2'(blk2 >> SB2), (SB2 > 0) ? blk2[SW2-1:0] : SW2'(0),
                 TW1'(blk1 >> SB1), (SB1 > 0) ? blk1[SW1-1:0] : SW1'(0),
                 in_write};
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign head     = buf_reg[rd_ptr_reg];
    assign {q_tag2, q_set2, q_tag1, q_set1, q_write} = head;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ===== rtl/tlc_back.sv =====
// ----------------------------------------------------------------------------
// tlc_back
// Sequencer: clearing pass, set read, lookup and update, result register.
// ----------------------------------------------------------------------------
module tlc_back #(
    parameter int CNW  = 8,
    parameter int LAST = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  logic                         q_write,
    output logic                         q_pop,
    output tlc_pkg::lvl_ctrl_t           l1_ctrl,
    output tlc_pkg::lvl_ctrl_t           l2_ctrl,
    output logic [CNW-1:0]               clr_cnt,
    input  logic                         l1_hit,
    input  logic                         l2_hit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tlc_pkg::STATUS_W-1:0] out_s1,
    output logic [tlc_pkg::STATUS_W-1:0] out_s2
);

    tlc_pkg::back_state_t state_reg, state_next;
    logic [CNW-1:0] cnt_reg;
    logic           m_valid_reg;
    logic [tlc_pkg::STATUS_W-1:0] s1_reg, s2_reg, s1_next, s2_next;
    logic           out_free;

    assign out_free  = !m_valid_reg || out_ready;
    assign out_valid = m_valid_reg;
    assign out_s1    = s1_reg;
    assign out_s2    = s2_reg;
    assign clr_cnt   = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlc_pkg::BK_CLEAR:
            begin
                if (cnt_reg == CNW'(LAST))
                begin
                    state_next = tlc_pkg::BK_IDLE;
                end
            end
            tlc_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = tlc_pkg::BK_LOOK;
                end
            end
            tlc_pkg::BK_LOOK:
            begin
                if (out_free)
                begin
                    state_next = tlc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tlc_pkg::BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        l1_ctrl = '0;
        l2_ctrl = '0;
        q_pop   = 1'b0;
        if (q_write)
        begin
            s1_next = l1_hit ? tlc_pkg::ST_WH : tlc_pkg::ST_WM;
            s2_next = l2_hit ? tlc_pkg::ST_WH : tlc_pkg::ST_WM;
        end
        else
        begin
            s1_next = l1_hit ? tlc_pkg::ST_RH : tlc_pkg::ST_RM;
            s2_next = l1_hit ? tlc_pkg::ST_NONE
                             : (l2_hit ? tlc_pkg::ST_RH : tlc_pkg::ST_RM);
        end
        unique case (state_reg)
            tlc_pkg::BK_CLEAR:
            begin
                l1_ctrl.clr_en = 1'b1;
                l2_ctrl.clr_en = 1'b1;
            end
            tlc_pkg::BK_IDLE:
            begin
                l1_ctrl.rd_en = q_valid;
                l2_ctrl.rd_en = q_valid;
            end
            tlc_pkg::BK_LOOK:
            begin
                q_pop          = out_free;
                l1_ctrl.upd_en = out_free;
                l1_ctrl.fill   = !q_write;
                l2_ctrl.upd_en = out_free && (q_write || !l1_hit);
                l2_ctrl.fill   = !q_write;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tlc_pkg::BK_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tlc_pkg::BK_CLEAR)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
            end
            if (q_pop)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_look_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlc_pkg::BK_LOOK) |-> q_valid)
        else $error("lookup without queued item");
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> out_free)
        else $error("result overwritten");
    a_pop_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_valid_reg)
        else $error("result lost");
    a_no_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
        l1_ctrl.clr_en |-> !q_pop && !l1_ctrl.rd_en)
        else $error("access during clearing pass");
`endif

endmodule

// ===== rtl/two_level_lru_cache_tags.sv =====
// ----------------------------------------------------------------------------
// two_level_lru_cache_tags
// Tag-only L1/L2 set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Input channel s_axis: tdata is the 32-bit byte address, tuser is the access
// kind (0 read, 1 write). Output channel m_axis: one item per request with
// tdata = {2'b0, l2_status, l1_status}.
// A request is decoded and queued by the front end (two entries). The back
// end reads the set rows of both levels (BK_IDLE), then compares all ways
// and updates ages, tags and valid bits (BK_LOOK); a new request is read
// only after the last one has left BK_LOOK. Between acceptance and the
// result lie the queue register, the set-row RAM read and the result register.
// After reset a clearing pass writes every set row of both levels;
// requests queue up (two) but are not processed until it ends.
// If m_axis_tready is low the result waits in the output register; the
// back end holds its lookup and the queue fills, then s_axis_tready drops.
// Set counts and block sizes must be powers of two.
// ----------------------------------------------------------------------------
module two_level_lru_cache_tags #(
    parameter int L1_SETS        = 64,
    parameter int L1_WAYS        = 4,
    parameter int L1_BLOCK_BYTES = 64,
    parameter int L2_SETS        = 256,
    parameter int L2_WAYS        = 8,
    parameter int L2_BLOCK_BYTES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tlc_pkg::ADDR_W-1:0]  s_axis_tdata,  // address[31:0]
    input  logic                        s_axis_tuser,  // req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tlc_pkg::OUT_W-1:0]   m_axis_tdata   // l1_status[2:0], l2_status[5:3]
);

    localparam int OFF1 = $clog2(L1_BLOCK_BYTES);
    localparam int SB1  = $clog2(L1_SETS);
    localparam int SW1  = (SB1 > 0) ? SB1 : 1;
    localparam int TW1  = tlc_pkg::ADDR_W - OFF1 - SB1;
    localparam int OFF2 = $clog2(L2_BLOCK_BYTES);
    localparam int SB2  = $clog2(L2_SETS);
    localparam int SW2  = (SB2 > 0) ? SB2 : 1;
    localparam int TW2  = tlc_pkg::ADDR_W - OFF2 - SB2;
    localparam int MAXS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
    localparam int CNW  = (MAXS > 1) ? $clog2(MAXS) : 1;

    logic           q_valid, q_pop, q_write;
    logic [SW1-1:0] q_set1;
    logic [TW1-1:0] q_tag1;
    logic [SW2-1:0] q_set2;
    logic [TW2-1:0] q_tag2;
    tlc_pkg::lvl_ctrl_t l1_ctrl, l2_ctrl;
    logic [CNW-1:0] clr_cnt;
    logic           l1_hit, l2_hit;
    logic [tlc_pkg::STATUS_W-1:0] s1, s2;

    tlc_front #(
        .OFF1(OFF1), .SB1(SB1), .SW1(SW1), .TW1(TW1),
        .OFF2(OFF2), .SB2(SB2), .SW2(SW2), .TW2(TW2)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_write(s_axis_tuser),
        .in_addr (s_axis_tdata),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_write (q_write),
        .q_set1  (q_set1),
        .q_tag1  (q_tag1),
        .q_set2  (q_set2),
        .q_tag2  (q_tag2)
    );

    tlc_level #(
        .SETS(L1_SETS), .WAYS(L1_WAYS), .TW(TW1)
    ) u_l1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (l1_ctrl),
        .rd_set (q_set1),
        .clr_set(SW1'(clr_cnt)),
        .tag    (q_tag1),
        .hit    (l1_hit)
    );

    tlc_level #(
        .SETS(L2_SETS), .WAYS(L2_WAYS), .TW(TW2)
    ) u_l2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (l2_ctrl),
        .rd_set (q_set2),
        .clr_set(SW2'(clr_cnt)),
        .tag    (q_tag2),
        .hit    (l2_hit)
    );

    tlc_back #(
        .CNW (CNW),
        .LAST(MAXS - 1)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_write  (q_write),
        .q_pop    (q_pop),
        .l1_ctrl  (l1_ctrl),
        .l2_ctrl  (l2_ctrl),
        .clr_cnt  (clr_cnt),
        .l1_hit   (l1_hit),
        .l2_hit   (l2_hit),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_s1   (s1),
        .out_s2   (s2)
    );

    assign m_axis_tdata = {2'b00, s2, s1};

endmodule

// ===== verif/two_level_lru_cache_tags_tb.sv =====
// ----------------------------------------------------------------------------
// two_level_lru_cache_tags_tb
// Drives read and write requests into the L1/L2 tag block and checks each
// status item against an in-bench true-LRU model of both cache levels.
// ----------------------------------------------------------------------------
module two_level_lru_cache_tags_tb;

    localparam int L1_SETS = 64;
    localparam int L1_WAYS = 4;
    localparam int L2_SETS = 256;
    localparam int L2_WAYS = 8;
    localparam int BLK     = 64;
    localparam int LIMIT   = 400000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [tlc_pkg::ADDR_W-1:0]   s_axis_tdata = '0;   // address[31:0]
    logic                         s_axis_tuser = 1'b0; // req_type
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [tlc_pkg::OUT_W-1:0]    m_axis_tdata;        // l1_status[2:0], l2_status[5:3]

    two_level_lru_cache_tags i_dut (.*);

    always #4 clk = ~clk;

    logic [25:0] l1_tag [L1_SETS][L1_WAYS];
    bit          l1_vld [L1_SETS][L1_WAYS];
    int          l1_age [L1_SETS][L1_WAYS];
    logic [23:0] l2_tag [L2_SETS][L2_WAYS];
    bit          l2_vld [L2_SETS][L2_WAYS];
    int          l2_age [L2_SETS][L2_WAYS];

    logic [5:0]  status_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;
    bit          rx_stall = 1'b0;

    // Returns 1 on hit; on miss with alloc, fills the oldest way.
    function automatic bit l1_access(int s, logic [25:0] tag, bit alloc);
        int hit;
        int mine;
        hit = -1;
        for (int w = 0; w < L1_WAYS; w++)
            if (hit < 0 && l1_vld[s][w] && l1_tag[s][w] == tag) hit = w;
        if (hit < 0 && !alloc) return 1'b0;
        if (hit < 0)
        begin
            for (int w = 0; w < L1_WAYS; w++)
                if (hit < 0 && l1_age[s][w] == L1_WAYS - 1) hit = w;
            l1_tag[s][hit] = tag;
            l1_vld[s][hit] = 1'b1;
            alloc = 1'b0;
        end
        else alloc = 1'b1;
        mine = l1_age[s][hit];
        for (int w = 0; w < L1_WAYS; w++)
            if (l1_age[s][w] < mine) l1_age[s][w]++;
        l1_age[s][hit] = 0;
        return alloc;
    endfunction

    function automatic bit l2_access(int s, logic [23:0] tag, bit alloc);
        int hit;
        int mine;
        hit = -1;
        for (int w = 0; w < L2_WAYS; w++)
            if (hit < 0 && l2_vld[s][w] && l2_tag[s][w] == tag) hit = w;
        if (hit < 0 && !alloc) return 1'b0;
        if (hit < 0)
        begin
            for (int w = 0; w < L2_WAYS; w++)
                if (hit < 0 && l2_age[s][w] == L2_WAYS - 1) hit = w;
            l2_tag[s][hit] = tag;
            l2_vld[s][hit] = 1'b1;
            alloc = 1'b0;
        end
        else alloc = 1'b1;
        mine = l2_age[s][hit];
        for (int w = 0; w < L2_WAYS; w++)
            if (l2_age[s][w] < mine) l2_age[s][w]++;
        l2_age[s][hit] = 0;
        return alloc;
    endfunction

    function automatic logic [5:0] cache_status(bit wr, logic [31:0] addr);
        logic [25:0] blk;
        logic [2:0]  s1;
        logic [2:0]  s2;
        blk = 26'(addr / BLK);
        if (!wr)
        begin
            if (l1_access(blk % L1_SETS, 26'(blk / L1_SETS), 1'b1))
            begin
                s1 = tlc_pkg::ST_RH;
                s2 = tlc_pkg::ST_NONE;
            end
            else
            begin
                s1 = tlc_pkg::ST_RM;
                s2 = l2_access(blk % L2_SETS, 24'(blk / L2_SETS), 1'b1) ?
                     tlc_pkg::ST_RH : tlc_pkg::ST_RM;
            end
        end
        else
        begin
            s1 = l1_access(blk % L1_SETS, 26'(blk / L1_SETS), 1'b0) ?
                 tlc_pkg::ST_WH : tlc_pkg::ST_WM;
            s2 = l2_access(blk % L2_SETS, 24'(blk / L2_SETS), 1'b0) ?
                 tlc_pkg::ST_WH : tlc_pkg::ST_WM;
        end
        return {s2, s1};
    endfunction

    task automatic send_req(bit wr, logic [31:0] addr);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= wr;
        s_axis_tdata  <= addr;
        do @(posedge clk); while (!s_axis_tready);
        status_q.push_back(cache_status(wr, addr));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
    endtask

    // Addresses from a small pool of tags so sets fill, evict and hit.
    function automatic logic [31:0] pool_addr(int n_tags, int n_sets);
        logic [31:0] a;
        a = $urandom;
        a[13:6] = 8'($urandom_range(0, n_sets - 1));
        a[31:14] = 18'($urandom_range(0, n_tags - 1) * 32'h0003_1);
        return a;
    endfunction

    task automatic test_directed();
        send_req(1'b0, 32'h0000_0000);
        send_req(1'b0, 32'h0000_003F);
        send_req(1'b1, 32'h0000_0010);
        send_req(1'b1, 32'hFFFF_FFFF);
        send_req(1'b0, 32'hFFFF_FFFF);
        send_req(1'b0, 32'hFFFF_FFC0);
        send_req(1'b1, 32'hFFFF_FFC0);
        send_req(1'b1, 32'h5555_5555);
        send_req(1'b0, 32'hAAAA_AAAA);
        // L1 conflict set 0: five tags evict the oldest; L2 still hits
        for (int t = 1; t <= 5; t++) send_req(1'b0, t << 12);
        send_req(1'b0, 32'h0000_1000);
        send_req(1'b1, 32'h0000_2000);
        // L2 set 0: nine tags evict in L2 too
        for (int t = 1; t <= 9; t++) send_req(1'b0, t << 14);
        send_req(1'b0, 32'h0000_4000);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 4 == 3) send_req(1'($urandom_range(0, 1)), $urandom);
            else send_req($urandom_range(0, 2) == 0, pool_addr(12, 4));
        end
    endtask

    task automatic test_drain_pause();
        wait_drain();
        repeat (5) @(posedge clk);
        test_random(50);
    endtask

    task automatic test_no_idle(int n);
        idle_en = 1'b0;
        test_random(n);
    endtask

    always @(posedge clk)
    begin
        logic [5:0] exp_st;
        if (rst_n)
        begin
            if (!idle_en) m_axis_tready <= 1'b1;
            else if (rx_stall) m_axis_tready <= 1'b0;
            else m_axis_tready <= $urandom_range(0, 4) != 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t unexpected item: actual %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_st = status_q.pop_front();
                    if (m_axis_tdata[2:0] !== exp_st[2:0])
                    begin
                        $display("%0t l1_status: expected %0d actual %0d",
                                 $time, exp_st[2:0], m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tdata[5:3] !== exp_st[5:3])
                    begin
                        $display("%0t l2_status: expected %0d actual %0d",
                                 $time, exp_st[5:3], m_axis_tdata[5:3]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        rx_stall <= idle_en && $urandom_range(0, 15) == 0 ? 1'b1 :
                    (rx_stall && $urandom_range(0, 3) != 0);
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("two_level_lru_cache_tags test failed");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < L1_SETS; s++)
            for (int w = 0; w < L1_WAYS; w++)
            begin
                l1_vld[s][w] = 1'b0;
                l1_age[s][w] = L1_WAYS - 1 - w;
            end
        for (int s = 0; s < L2_SETS; s++)
            for (int w = 0; w < L2_WAYS; w++)
            begin
                l2_vld[s][w] = 1'b0;
                l2_age[s][w] = L2_WAYS - 1 - w;
            end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(700);
        test_drain_pause();
        test_no_idle(250);
        wait_drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("two_level_lru_cache_tags test passed");
        else
            $display("two_level_lru_cache_tags test failed");
        $finish;
    end

endmodule
